@@ sv/tdsd_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tdsd_pkg
// Shared types, codes and the segment table for the display scan driver.
// ---------------------------------------------------------------------------
package tdsd_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int CODE_W     = 4;
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_SET    = 2'd1;
    localparam logic [1:0] MODE_BLANK  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [CODE_W-1:0]     BLANK_CODE  = 4'd10;
    localparam logic [NUM_DIGITS-1:0] UNITS_POINT = 4'b0100;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_SET,
        KIND_BLANK
    } tdsd_kind_t;

    typedef logic [NUM_DIGITS-1:0][CODE_W-1:0] tdsd_codes_t;

    typedef struct packed {
        tdsd_kind_t  kind;
        tdsd_codes_t codes;
    } tdsd_entry_t;

    localparam logic [6:0] SEG_ROM [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // Active-high segments a..g; codes ten and up are blank.
    function automatic logic [6:0] seg_decode(input logic [CODE_W-1:0] code);
        logic [6:0] seg;
        if (code < BLANK_CODE) begin
            seg = SEG_ROM[code];
        end else begin
            seg = 7'h00;
        end
        return seg;
    endfunction

endpackage
`default_nettype wire

@@ sv/tdsd_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tdsd_front
// Takes beats, drops unused modes, splits temperatures into digit codes.
// ---------------------------------------------------------------------------
module tdsd_front
    import tdsd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  in_mode,
    input  wire logic [15:0] in_temp,
    output logic             out_valid,
    input  wire logic        out_ready,
    output tdsd_entry_t      out_entry
);

    logic             v1_reg, v2_reg, v3_reg;
    tdsd_kind_t       kind1_reg, kind2_reg;
    logic [12:0]      whole1_reg;
    logic [3:0]       tenths1_reg, tenths2_reg, units2_reg;
    logic [9:0]       w10_2_reg;
    tdsd_entry_t      entry3_reg;

    logic             adv;
    logic             take;
    tdsd_kind_t       kind0;
    logic [31:0]      prod1;
    logic [12:0]      whole0;
    logic [15:0]      rem0;
    logic [25:0]      prod2;
    logic [9:0]       w10_1;
    logic [12:0]      rem1;
    logic [17:0]      prod3;
    logic [6:0]       hund2;
    logic [9:0]       rem2;
    tdsd_entry_t      entry_next;

    assign adv      = !v3_reg || out_ready;
    assign in_ready = adv;
    assign take     = in_valid && (in_mode != MODE_UNUSED);

    always_comb begin
        unique case (in_mode)
            MODE_SET:   kind0 = KIND_SET;
            MODE_BLANK: kind0 = KIND_BLANK;
            default:    kind0 = KIND_TICK;
        endcase
    end

    // t / 10 by reciprocal, exact over 16 bits
    assign prod1  = in_temp * 32'd52429;
    assign whole0 = prod1[31:19];
    assign rem0   = in_temp - ({3'b000, whole0} * 16'd10);

    // whole / 10, exact for whole below 6554
    assign prod2 = whole1_reg * 13'd6554;
    assign w10_1 = prod2[25:16];
    assign rem1  = whole1_reg - ({3'b000, w10_1} * 13'd10);

    // (whole / 10) / 10, exact below 1029
    assign prod3 = w10_2_reg * 8'd205;
    assign hund2 = prod3[17:11];
    assign rem2  = w10_2_reg - ({3'b000, hund2} * 10'd10);

    always_comb begin
        entry_next.kind     = kind2_reg;
        entry_next.codes[0] = ((w10_2_reg >= 10'd10) && (hund2 < 7'd10))
                              ? hund2[3:0] : BLANK_CODE;
        entry_next.codes[1] = (w10_2_reg != 10'd0) ? rem2[3:0] : BLANK_CODE;
        entry_next.codes[2] = units2_reg;
        entry_next.codes[3] = tenths2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            kind1_reg   <= kind0;
            whole1_reg  <= whole0;
            tenths1_reg <= rem0[3:0];
            kind2_reg   <= kind1_reg;
            w10_2_reg   <= w10_1;
            units2_reg  <= rem1[3:0];
            tenths2_reg <= tenths1_reg;
            entry3_reg  <= entry_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_entry = entry3_reg;

endmodule
`default_nettype wire

@@ sv/tdsd_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tdsd_queue
// Four-entry register queue between the front and the back.
// ---------------------------------------------------------------------------
module tdsd_queue
    import tdsd_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire tdsd_entry_t push_entry,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output tdsd_entry_t pop_entry
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    tdsd_entry_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             push, pop;

    assign push_ready = (count_reg != (PTR_W+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

@@ sv/tdsd_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tdsd_back
// Holds the digit codes and scan index; decodes one digit per tick.
// ---------------------------------------------------------------------------
module tdsd_back
    import tdsd_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire tdsd_entry_t in_entry,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic [7:0]  out_seg_n,
    output logic [NUM_DIGITS-1:0] out_en_n
);

    tdsd_codes_t           codes_reg;
    logic [NUM_DIGITS-1:0] point_reg;
    logic [IDX_W-1:0]      scan_reg;
    logic                  m_valid_reg;
    logic [7:0]            seg_n_reg;
    logic [NUM_DIGITS-1:0] en_n_reg;

    logic                  is_tick;
    logic                  out_free;
    logic                  pop;
    logic [7:0]            pattern;

    assign is_tick  = (in_entry.kind == KIND_TICK);
    assign out_free = !m_valid_reg || out_ready;
    assign in_ready = !is_tick || out_free;
    assign pop      = in_valid && in_ready;
    assign pattern  = {point_reg[scan_reg], seg_decode(codes_reg[scan_reg])};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg   <= {NUM_DIGITS{BLANK_CODE}};
            point_reg   <= '0;
            scan_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // a new tick beat wins over the drain of the previous one
            if (pop && is_tick) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (pop) begin
                unique case (in_entry.kind)
                    KIND_SET: begin
                        codes_reg <= in_entry.codes;
                        point_reg <= UNITS_POINT;
                    end
                    KIND_BLANK: begin
                        codes_reg <= {NUM_DIGITS{BLANK_CODE}};
                        point_reg <= '0;
                    end
                    default: begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && is_tick) begin
            seg_n_reg <= ~pattern;
            en_n_reg  <= ~(NUM_DIGITS'(1) << scan_reg);
        end
    end

    assign out_valid = m_valid_reg;
    assign out_seg_n = seg_n_reg;
    assign out_en_n  = en_n_reg;

`ifndef SYNTH
    a_en_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> $onehot(~en_n_reg))
        else $error("digit enable not one-hot low");

    a_scan_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && is_tick) |=> (scan_reg == $past(scan_reg) + 1'b1) && m_valid_reg)
        else $error("scan index did not advance on tick");

    a_blank_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && (in_entry.kind == KIND_BLANK)) |=> (point_reg == '0))
        else $error("blank did not clear decimal point");
`endif

endmodule
`default_nettype wire

@@ sv/temperature_display_scan_driver.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// temperature_display_scan_driver
// A refresh tick beat accepted on s_ shows up on m_ as a result after passing
//   three conversion stages, the queue, then the output register.
// Throughput: one beat per cycle unless m_ stalls; set and blank give no result.
// Reset (aresetn low, synchronous): all digits blank, point off, scan at
//   the leftmost digit, queue and pipeline empty.
// ---------------------------------------------------------------------------
module temperature_display_scan_driver
    import tdsd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] temperature_tenths
    input  wire logic [1:0]  s_tuser,   // [1:0] mode
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [7:0] segments_n, [11:8] digit_enable_n,
                                        // [15:12] zero
);

    // Front: conversion pipeline. Every set, blank and tick beat passes through it
    // so that they reach the display state in order; unused-mode beats are dropped.
    logic        fr_valid, fr_ready;
    tdsd_entry_t fr_entry;

    // Back side of the queue.
    logic        bk_valid, bk_ready;
    tdsd_entry_t bk_entry;

    logic [7:0]            seg_n;
    logic [NUM_DIGITS-1:0] en_n;

    tdsd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_temp   (s_tdata),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_entry (fr_entry)
    );

    // Short queue so the scan side can stall on the output without
    // immediately backing up the conversion pipeline.
    tdsd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_entry (fr_entry),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_entry  (bk_entry)
    );

    // Back: applies set/blank to the digit registers, turns ticks into
    // active-low segment and enable patterns in the output register.
    tdsd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (bk_valid),
        .in_ready  (bk_ready),
        .in_entry  (bk_entry),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_seg_n (seg_n),
        .out_en_n  (en_n)
    );

    // Pack result fields, lowest field first, padded to 16 bits.
    assign m_tdata = {4'b0000, en_n, seg_n};

endmodule
`default_nettype wire
